FILE: hdl/mtsc_pkg.sv
// Shared types, codes and reset constants of the match timer with start cord.
`default_nettype none

package mtsc_pkg;

    // Field widths of the beats and registers.
    localparam int OP_W        = 2;
    localparam int SERVO_VAL_W = 16;
    localparam int ELAPSED_W   = 25;
    localparam int DEB_W       = 5;
    localparam int TICKS_W     = 24;
    localparam int AVOID_W     = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    // Default sizes of the counters.
    localparam int SERVO_TIMER_WIDTH_DEF   = 16;
    localparam int MATCH_COUNTER_WIDTH_DEF = 25;

    // Register reset values.
    localparam logic [DEB_W-1:0]   DEBOUNCE_LIMIT_RST = 5'd30;
    localparam logic [TICKS_W-1:0] MATCH_TICKS_RST    = 24'd90000;
    localparam logic [TICKS_W-1:0] WATCH_LIMIT_RST    = 24'd1000;
    localparam logic [AVOID_W-1:0] AVOID_PERIOD_RST   = 4'd10;
    localparam logic [AVOID_W-1:0] AVOID_COUNT_RST    = 4'd10;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_TICKS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WATCH_LIMIT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AVOID_PERIOD   = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_TICK        = 2'd0,
        OP_CLEAR_WATCH = 2'd1,
        OP_LOAD_SERVO  = 2'd2,
        OP_NONE        = 2'd3
    } t_op;

    typedef struct packed {
        t_op                    op;
        logic                   cord_pin;
        logic                   motion_active;
        logic [SERVO_VAL_W-1:0] servo_timeout_value;
    } t_item;

    typedef struct packed {
        logic                 start_event;
        logic                 end_event;
        logic                 done_event;
        logic                 free_motion;
        logic                 avoid_event;
        logic                 match_over;
        logic                 armed;
        logic                 urgent_priority;
        logic                 servo_waiting;
        logic [ELAPSED_W-1:0] elapsed_ticks;
    } t_result;

    // Handshake between the input register and the result register.
    typedef struct packed {
        logic fire;
    } t_flow;

endpackage

`default_nettype wire

FILE: hdl/mtsc_in_reg.sv
// Input register stage that holds one accepted beat until the core consumes it.
`default_nettype none

module mtsc_in_reg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire mtsc_pkg::t_item i_item,
    input  wire logic           i_room,
    output mtsc_pkg::t_flow     o_flow,
    output mtsc_pkg::t_item     o_item
);

    logic            r_valid;
    logic            n_valid;
    mtsc_pkg::t_item r_item;
    logic            w_fire;
    logic            w_accept;

    assign w_fire   = r_valid && i_room;
    assign o_stall  = r_valid && !i_room;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (w_fire) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_flow.fire  = w_fire;
    assign o_item       = r_item;

endmodule

`default_nettype wire

FILE: hdl/mtsc_core.sv
// Configuration registers, timer state and the per-beat next-state logic.
`default_nettype none

module mtsc_core #(
    parameter int SERVO_TIMER_WIDTH   = mtsc_pkg::SERVO_TIMER_WIDTH_DEF,
    parameter int MATCH_COUNTER_WIDTH = mtsc_pkg::MATCH_COUNTER_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [mtsc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [mtsc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_fire,
    input  wire mtsc_pkg::t_item                     i_item,
    output mtsc_pkg::t_result                        o_result
);

    localparam int SW = SERVO_TIMER_WIDTH;
    localparam int MW = MATCH_COUNTER_WIDTH;
    localparam logic [MW-1:0] MCAP = {MW{1'b1}} - MW'(2);

    logic [mtsc_pkg::DEB_W-1:0]   r_debounce_limit;
    logic [mtsc_pkg::TICKS_W-1:0] r_match_ticks;
    logic [mtsc_pkg::TICKS_W-1:0] r_watch_limit;
    logic [mtsc_pkg::AVOID_W-1:0] r_avoid_period;

    logic [mtsc_pkg::DEB_W-1:0]   r_cord_count,  n_cord_count;
    logic                         r_cord_armed,  n_cord_armed;
    logic                         r_running,     n_running;
    logic [MW-1:0]                r_match_count, n_match_count;
    logic                         r_over,        n_over;
    logic                         r_urgent,      n_urgent;
    logic [mtsc_pkg::TICKS_W-1:0] r_watch_count, n_watch_count;
    logic [mtsc_pkg::AVOID_W-1:0] r_avoid_count, n_avoid_count;
    logic [SW-1:0]                r_servo_count, n_servo_count;

    logic [mtsc_pkg::DEB_W-1:0] w_lim;
    logic [MW-1:0]              w_mlen;
    logic [MW-1:0]              w_mlen_p1;
    logic [31:0]                w_servo_ext;
    logic [31:0]                w_count_ext;
    logic                       w_start, w_end, w_done, w_release, w_avoid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_limit <= mtsc_pkg::DEBOUNCE_LIMIT_RST;
            r_match_ticks    <= mtsc_pkg::MATCH_TICKS_RST;
            r_watch_limit    <= mtsc_pkg::WATCH_LIMIT_RST;
            r_avoid_period   <= mtsc_pkg::AVOID_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mtsc_pkg::REG_DEBOUNCE_LIMIT: begin
                    r_debounce_limit <= i_cfg_data[mtsc_pkg::DEB_W-1:0];
                end
                mtsc_pkg::REG_MATCH_TICKS: begin
                    r_match_ticks <= i_cfg_data[mtsc_pkg::TICKS_W-1:0];
                end
                mtsc_pkg::REG_WATCH_LIMIT: begin
                    r_watch_limit <= i_cfg_data[mtsc_pkg::TICKS_W-1:0];
                end
                mtsc_pkg::REG_AVOID_PERIOD: begin
                    r_avoid_period <= i_cfg_data[mtsc_pkg::AVOID_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // A zero debounce limit behaves as one; the match length is clamped so
    // that the counter can step two past it without wrapping.
    assign w_lim = (r_debounce_limit == '0) ? mtsc_pkg::DEB_W'(1) : r_debounce_limit;
    assign w_mlen = (33'(r_match_ticks) > 33'(MCAP)) ? MCAP : MW'(r_match_ticks);
    assign w_mlen_p1 = w_mlen + MW'(1);
    assign w_servo_ext = 32'(i_item.servo_timeout_value);

    always_comb begin
        n_cord_count  = r_cord_count;
        n_cord_armed  = r_cord_armed;
        n_running     = r_running;
        n_match_count = r_match_count;
        n_over        = r_over;
        n_urgent      = r_urgent;
        n_watch_count = r_watch_count;
        n_avoid_count = r_avoid_count;
        n_servo_count = r_servo_count;
        w_start       = 1'b0;
        w_end         = 1'b0;
        w_done        = 1'b0;
        w_release     = 1'b0;
        w_avoid       = 1'b0;
        case (i_item.op)
            mtsc_pkg::OP_CLEAR_WATCH: begin
                n_watch_count = '0;
            end
            mtsc_pkg::OP_LOAD_SERVO: begin
                n_servo_count = w_servo_ext[SW-1:0];
            end
            mtsc_pkg::OP_TICK: begin
                if (i_item.cord_pin) begin
                    if (r_cord_count < w_lim) begin
                        n_cord_count = r_cord_count + mtsc_pkg::DEB_W'(1);
                    end
                end else if (r_cord_count != '0) begin
                    n_cord_count = r_cord_count - mtsc_pkg::DEB_W'(1);
                end

                if (r_cord_armed) begin
                    if (n_cord_count == '0) begin
                        n_cord_armed  = 1'b0;
                        n_running     = 1'b1;
                        n_match_count = '0;
                        n_urgent      = 1'b1;
                        w_start       = 1'b1;
                    end
                end else if (n_cord_count >= w_lim) begin
                    n_cord_armed  = 1'b1;
                    n_running     = 1'b0;
                    n_match_count = '0;
                    n_urgent      = 1'b0;
                end

                n_avoid_count = r_avoid_count - mtsc_pkg::AVOID_W'(1);
                if (n_avoid_count == '0) begin
                    w_avoid       = 1'b1;
                    n_avoid_count = r_avoid_period;
                end

                if (r_servo_count != '0) begin
                    n_servo_count = r_servo_count - SW'(1);
                end

                if (i_item.motion_active) begin
                    if (r_watch_count >= r_watch_limit) begin
                        w_release = 1'b1;
                        w_done    = 1'b1;
                    end else begin
                        n_watch_count = r_watch_count + mtsc_pkg::TICKS_W'(1);
                    end
                end

                if (n_match_count < w_mlen) begin
                    if (n_running) begin
                        n_match_count = n_match_count + MW'(1);
                    end else begin
                        n_match_count = '0;
                    end
                    n_over = 1'b0;
                end else if (n_match_count == w_mlen) begin
                    n_match_count = n_match_count + MW'(1);
                    n_urgent      = 1'b0;
                    n_over        = 1'b1;
                end else if (n_match_count == w_mlen_p1) begin
                    n_match_count = n_match_count + MW'(1);
                    w_end         = 1'b1;
                end else begin
                    w_release = 1'b1;
                    n_over    = 1'b1;
                    if (!n_running) begin
                        n_match_count = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cord_count  <= '0;
            r_cord_armed  <= 1'b0;
            r_running     <= 1'b0;
            r_match_count <= '0;
            r_over        <= 1'b0;
            r_urgent      <= 1'b0;
            r_watch_count <= '0;
            r_avoid_count <= mtsc_pkg::AVOID_COUNT_RST;
            r_servo_count <= '0;
        end else if (i_fire) begin
            r_cord_count  <= n_cord_count;
            r_cord_armed  <= n_cord_armed;
            r_running     <= n_running;
            r_match_count <= n_match_count;
            r_over        <= n_over;
            r_urgent      <= n_urgent;
            r_watch_count <= n_watch_count;
            r_avoid_count <= n_avoid_count;
            r_servo_count <= n_servo_count;
        end
    end

    assign w_count_ext = 32'(n_match_count);

    assign o_result.start_event     = w_start;
    assign o_result.end_event       = w_end;
    assign o_result.done_event      = w_done;
    assign o_result.free_motion     = w_release;
    assign o_result.avoid_event     = w_avoid;
    assign o_result.match_over      = n_over;
    assign o_result.armed           = n_cord_armed;
    assign o_result.urgent_priority = n_urgent;
    assign o_result.servo_waiting   = (n_servo_count != '0);
    assign o_result.elapsed_ticks   = w_count_ext[mtsc_pkg::ELAPSED_W-1:0];

endmodule

`default_nettype wire

FILE: hdl/mtsc_out_reg.sv
// Result register that holds one finished beat until the receiver takes it.
`default_nettype none

module mtsc_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mtsc_pkg::t_flow   i_flow,
    input  wire mtsc_pkg::t_result i_result,
    output logic                   o_room,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output mtsc_pkg::t_result      o_result
);

    logic              r_valid;
    logic              n_valid;
    mtsc_pkg::t_result r_result;

    // The register can take a new result when empty or when its beat leaves.
    assign o_room = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_flow.fire) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flow.fire) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

FILE: hdl/match_timer_with_start_cord_top.sv
// Top level of the match timer with start cord: ports, stage wiring and checks.
//
// Every input beat (a tick or a command) produces exactly one result beat.
// A beat is registered on entry, its whole update (debounce, arm and start,
// avoidance pulse, servo timeout, motion watchdog and match counter) is
// worked out combinationally from that register and the timer state, and the
// result lands in an output register. The result is valid once the beat
// has moved into that register, and one beat can enter every cycle while the
// receiver keeps taking results; the only limit on rate is the single-entry
// result register, which holds back the input stage while its beat is stalled.
// Configuration registers may be written at any time the block holds no beat.
`default_nettype none

module match_timer_with_start_cord_top #(
    parameter int SERVO_TIMER_WIDTH   = mtsc_pkg::SERVO_TIMER_WIDTH_DEF,
    parameter int MATCH_COUNTER_WIDTH = mtsc_pkg::MATCH_COUNTER_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write port.
    input  wire logic                                i_cfg_we,
    input  wire logic [mtsc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [mtsc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input channel.
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [mtsc_pkg::OP_W-1:0]           i_op,
    input  wire logic                                i_cord_pin,
    input  wire logic                                i_motion_active,
    input  wire logic [mtsc_pkg::SERVO_VAL_W-1:0]    i_servo_timeout_value,
    // Output channel.
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_start_event,
    output logic                                     o_end_event,
    output logic                                     o_done_event,
    output logic                                     o_free_motion,
    output logic                                     o_avoid_event,
    output logic                                     o_match_over,
    output logic                                     o_armed,
    output logic                                     o_urgent_priority,
    output logic                                     o_servo_waiting,
    output logic [mtsc_pkg::ELAPSED_W-1:0]           o_elapsed_ticks
);

    mtsc_pkg::t_item   w_in_item;
    mtsc_pkg::t_item   w_item;
    mtsc_pkg::t_flow   w_flow;
    mtsc_pkg::t_result w_next_result;
    mtsc_pkg::t_result w_result;
    logic              w_room;

    // Gather the input fields into one beat.
    assign w_in_item.op                  = mtsc_pkg::t_op'(i_op);
    assign w_in_item.cord_pin            = i_cord_pin;
    assign w_in_item.motion_active       = i_motion_active;
    assign w_in_item.servo_timeout_value = i_servo_timeout_value;

    // Entry register: the beat waits here until the result register has room.
    mtsc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (w_in_item),
        .i_room  (w_room),
        .o_flow  (w_flow),
        .o_item  (w_item)
    );

    // Timer state and its combinational update; the state advances only when
    // the beat moves into the result register.
    mtsc_core #(
        .SERVO_TIMER_WIDTH   (SERVO_TIMER_WIDTH),
        .MATCH_COUNTER_WIDTH (MATCH_COUNTER_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (w_flow.fire),
        .i_item      (w_item),
        .o_result    (w_next_result)
    );

    // Result register toward the receiver.
    mtsc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_flow   (w_flow),
        .i_result (w_next_result),
        .o_room   (w_room),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (w_result)
    );

    assign o_start_event     = w_result.start_event;
    assign o_end_event       = w_result.end_event;
    assign o_done_event      = w_result.done_event;
    assign o_free_motion     = w_result.free_motion;
    assign o_avoid_event     = w_result.avoid_event;
    assign o_match_over      = w_result.match_over;
    assign o_armed           = w_result.armed;
    assign o_urgent_priority = w_result.urgent_priority;
    assign o_servo_waiting   = w_result.servo_waiting;
    assign o_elapsed_ticks   = w_result.elapsed_ticks;

    // No result beat is offered in the cycle after reset.
    a_no_beat_after_reset: assert property (
        @(posedge i_clk) !i_rst_n |=> !o_out_valid
    ) else $error("result beat valid right after reset");

    // Pulling the cord disarms the block in the same beat that starts the match.
    a_start_disarms: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_start_event) |-> !o_armed
    ) else $error("start event reported while still armed");

    // A watchdog expiry always comes with a motor release request.
    a_done_releases: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_event) |-> o_free_motion
    ) else $error("done event without motion release");

    // Urgent priority belongs to a running match, never to an armed block.
    a_armed_not_urgent: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_armed) |-> !o_urgent_priority
    ) else $error("urgent priority raised while armed");

endmodule

`default_nettype wire
